// ----- src/abld_pkg.sv -----
package abld_pkg;

    // block sizes
    localparam int ANCHORS         = 4;
    localparam int LANDMARK_POINTS = 5;
    localparam int ANCHOR_REGS     = 4;
    localparam int FRAC_BITS       = 12;
    localparam int BIT_W           = $clog2(FRAC_BITS);

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_SCORE       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_STRIDE     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ANCHOR_SIZE_0   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ANCHOR_SIZE_1   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_ANCHOR_SIZE_2   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_ANCHOR_SIZE_3   = 3'd5;

    // pair codes
    localparam logic [2:0] PAIR_CENTRE         = 3'd0;
    localparam logic [2:0] PAIR_SIZE           = 3'd1;
    localparam logic [2:0] PAIR_FIRST_LANDMARK = 3'd2;

    // record kinds
    localparam logic REC_BOX   = 1'b0;
    localparam logic REC_POINT = 1'b1;

    // exp(i) for integer part i = -8..7, unsigned q.24, indexed by i + 8
    localparam logic [35:0] EXP_INT [16] = '{
        36'd5628,       36'd15299,      36'd41587,      36'd113044,
        36'd307285,     36'd835288,     36'd2270549,    36'd6171993,
        36'd16777216,   36'd45605201,   36'd123967790,  36'd336979391,
        36'd916004956,  36'd2489959628, 36'd6768412009, 36'd18398451372
    };

    // exp(2^(k-12)) in q.16
    localparam logic [16:0] EXP_FRAC [FRAC_BITS] = '{
        17'd65552, 17'd65568, 17'd65600, 17'd65664, 17'd65793, 17'd66050,
        17'd66568, 17'd67616, 17'd69763, 17'd74262, 17'd84150, 17'd108051
    };

    typedef struct packed {
        logic [9:0]         grid_row;
        logic [9:0]         grid_col;
        logic [1:0]         anchor_index;
        logic [15:0]        score;
        logic [2:0]         pair_index;
        logic signed [15:0] delta_a;
        logic signed [15:0] delta_b;
    } t_in_item;

    typedef struct packed {
        logic               record_kind;
        logic signed [23:0] value_a;
        logic signed [23:0] value_b;
        logic signed [23:0] value_c;
        logic signed [23:0] value_d;
        logic [15:0]        kept_score;
        logic [2:0]         point_number;
        logic               last_of_anchor;
    } t_out_item;

    typedef struct packed {
        logic [15:0]                  min_score;
        logic [6:0]                   grid_stride;
        logic [ANCHOR_REGS-1:0][9:0]  anchor_size;
    } t_cfg;

    typedef struct packed {
        logic             load_item;
        logic             place_mul;
        logic             place_fin;
        logic             exp_init;
        logic             exp_mul;
        logic             exp_add;
        logic             size_mul;
        logic             size_add;
        logic             box_fin;
        logic             out_load;
        logic             sel_b;
        logic [BIT_W-1:0] bit_idx;
    } t_dp_cmd;

    typedef struct packed {
        logic pair_zero;
        logic pair_size;
        logic landmark_ok;
        logic passed;
        logic frac_set;
    } t_dp_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_PLACE_MUL,
        ST_PLACE_FIN,
        ST_EXP_INIT,
        ST_EXP_TEST,
        ST_EXP_MUL,
        ST_EXP_ADD,
        ST_SIZE_MUL,
        ST_SIZE_ADD,
        ST_BOX_FIN,
        ST_EMIT
    } t_state;

endpackage

// ----- src/abld_in_if.sv -----
interface abld_in_if;
    logic                valid;
    logic                ready;
    abld_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/abld_out_if.sv -----
interface abld_out_if;
    logic                valid;
    logic                ready;
    abld_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/abld_cfg_regs.sv -----
module abld_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [abld_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [abld_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output abld_pkg::t_cfg                     o_cfg
);

    abld_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_score       <= 16'd32768;
            r_cfg.grid_stride     <= 7'd4;
            r_cfg.anchor_size[0]  <= 10'd16;
            r_cfg.anchor_size[1]  <= 10'd32;
            r_cfg.anchor_size[2]  <= 10'd64;
            r_cfg.anchor_size[3]  <= 10'd128;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                abld_pkg::CFG_MIN_SCORE:       r_cfg.min_score <= i_cfg_data;
                abld_pkg::CFG_GRID_STRIDE:     r_cfg.grid_stride <= i_cfg_data[6:0];
                abld_pkg::CFG_ANCHOR_SIZE_0:   r_cfg.anchor_size[0] <= i_cfg_data[9:0];
                abld_pkg::CFG_ANCHOR_SIZE_1:   r_cfg.anchor_size[1] <= i_cfg_data[9:0];
                abld_pkg::CFG_ANCHOR_SIZE_2:   r_cfg.anchor_size[2] <= i_cfg_data[9:0];
                abld_pkg::CFG_ANCHOR_SIZE_3:   r_cfg.anchor_size[3] <= i_cfg_data[9:0];
                default: ; // unknown index, write dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- src/abld_ctrl.sv -----
module abld_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    input  abld_pkg::t_dp_status    i_status,
    output abld_pkg::t_dp_cmd       o_cmd
);

    localparam logic [abld_pkg::BIT_W-1:0] BIT_LAST =
        abld_pkg::BIT_W'(abld_pkg::FRAC_BITS - 1);

    abld_pkg::t_state             r_state, n_state;
    logic [abld_pkg::BIT_W-1:0]   r_bit, n_bit;
    logic                         r_sel_b, n_sel_b;
    logic                         r_out_valid, n_out_valid;
    logic                         w_in_fire;
    logic                         w_out_free;

    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= abld_pkg::ST_IDLE;
            r_bit       <= '0;
            r_sel_b     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bit       <= n_bit;
            r_sel_b     <= n_sel_b;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_bit         = r_bit;
        n_sel_b       = r_sel_b;
        o_in_ready    = 1'b0;
        o_cmd         = '0;
        o_cmd.sel_b   = r_sel_b;
        o_cmd.bit_idx = r_bit;
        case (r_state)
            abld_pkg::ST_IDLE: begin
                // ready is high throughout idle, so valid alone takes the request
                o_in_ready      = 1'b1;
                o_cmd.load_item = i_in_valid;
                if (i_in_valid) begin
                    n_state = abld_pkg::ST_DECODE;
                end
            end
            abld_pkg::ST_DECODE: begin
                if (i_status.pair_zero) begin
                    n_state = abld_pkg::ST_PLACE_MUL;
                end else if (!i_status.passed) begin
                    n_state = abld_pkg::ST_IDLE;
                end else if (i_status.pair_size) begin
                    n_sel_b = 1'b0;
                    n_state = abld_pkg::ST_EXP_INIT;
                end else if (i_status.landmark_ok) begin
                    n_state = abld_pkg::ST_PLACE_MUL;
                end else begin
                    n_state = abld_pkg::ST_IDLE;
                end
            end
            abld_pkg::ST_PLACE_MUL: begin
                o_cmd.place_mul = 1'b1;
                n_state         = abld_pkg::ST_PLACE_FIN;
            end
            abld_pkg::ST_PLACE_FIN: begin
                o_cmd.place_fin = 1'b1;
                n_state = i_status.pair_zero ? abld_pkg::ST_IDLE : abld_pkg::ST_EMIT;
            end
            abld_pkg::ST_EXP_INIT: begin
                o_cmd.exp_init = 1'b1;
                n_bit          = BIT_LAST;
                n_state        = abld_pkg::ST_EXP_TEST;
            end
            abld_pkg::ST_EXP_TEST: begin
                if (i_status.frac_set) begin
                    n_state = abld_pkg::ST_EXP_MUL;
                end else if (r_bit == '0) begin
                    n_state = abld_pkg::ST_SIZE_MUL;
                end else begin
                    n_bit = r_bit - 1'b1;
                end
            end
            abld_pkg::ST_EXP_MUL: begin
                o_cmd.exp_mul = 1'b1;
                n_state       = abld_pkg::ST_EXP_ADD;
            end
            abld_pkg::ST_EXP_ADD: begin
                o_cmd.exp_add = 1'b1;
                if (r_bit == '0) begin
                    n_state = abld_pkg::ST_SIZE_MUL;
                end else begin
                    n_bit   = r_bit - 1'b1;
                    n_state = abld_pkg::ST_EXP_TEST;
                end
            end
            abld_pkg::ST_SIZE_MUL: begin
                o_cmd.size_mul = 1'b1;
                n_state        = abld_pkg::ST_SIZE_ADD;
            end
            abld_pkg::ST_SIZE_ADD: begin
                o_cmd.size_add = 1'b1;
                if (!r_sel_b) begin
                    n_sel_b = 1'b1;
                    n_state = abld_pkg::ST_EXP_INIT;
                end else begin
                    n_state = abld_pkg::ST_BOX_FIN;
                end
            end
            abld_pkg::ST_BOX_FIN: begin
                o_cmd.box_fin = 1'b1;
                n_state       = abld_pkg::ST_EMIT;
            end
            abld_pkg::ST_EMIT: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = abld_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = abld_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    a_fire_to_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> (r_state == abld_pkg::ST_DECODE))
        else $error("accepted request not decoded next cycle");

    a_bit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == abld_pkg::ST_EXP_TEST || r_state == abld_pkg::ST_EXP_ADD)
        |-> (r_bit <= BIT_LAST))
        else $error("fraction bit counter out of range");

    a_emit_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == abld_pkg::ST_EMIT && r_out_valid && !i_out_ready)
        |=> (r_state == abld_pkg::ST_EMIT))
        else $error("result left emit while output register busy");

endmodule

// ----- src/abld_datapath.sv -----
module abld_datapath (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  abld_pkg::t_cfg          i_cfg,
    input  abld_pkg::t_in_item      i_item,
    input  abld_pkg::t_dp_cmd       i_cmd,
    output abld_pkg::t_dp_status    o_status,
    output abld_pkg::t_out_item     o_result
);

    localparam logic [1:0] LAST_ANCHOR = 2'(abld_pkg::ANCHORS - 1);
    localparam logic [3:0] LP_W        = 4'(abld_pkg::LANDMARK_POINTS);
    localparam logic [53:0] ROUND_EXP  = 54'd32768;
    localparam logic [53:0] ROUND_SIZE = 54'd65536;

    function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
        if (v > 32'sd8388607) begin
            return 24'sh7FFFFF;
        end else if (v < -32'sd8388608) begin
            return 24'sh800000;
        end
        return signed'(v[23:0]);
    endfunction

    // floor((prod + 8) / 16) + base * 256, saturated
    function automatic logic signed [23:0] place_sum(input logic signed [26:0] prod,
                                                     input logic [16:0] base);
        logic signed [27:0] rounded;
        logic signed [27:0] total;
        rounded = (28'(prod) + 28'sd8) >>> 4;
        total   = rounded + signed'({3'b000, base, 8'h00});
        return sat24(32'(total));
    endfunction

    abld_pkg::t_in_item   r_item;
    abld_pkg::t_out_item  r_res;
    abld_pkg::t_out_item  r_out;

    logic                 r_passed;
    logic signed [23:0]   r_cx;
    logic signed [23:0]   r_cy;
    logic [15:0]          r_held_score;

    logic signed [26:0]   r_prod_a, r_prod_b;
    logic [16:0]          r_base_x, r_base_y;

    logic [35:0]          r_e;
    logic [34:0]          r_plo, r_phi;
    logic [29:0]          r_hw, r_hh;

    logic [1:0]           w_aidx;
    logic [9:0]           w_size;
    logic signed [10:0]   w_size_s;
    logic [15:0]          w_raw;
    logic [16:0]          w_mul_op;
    logic [53:0]          w_acc;
    logic [2:0]           w_pt;
    logic                 w_pair_zero;
    logic                 w_landmark_ok;
    logic                 w_last;
    logic signed [23:0]   w_place_a, w_place_b;

    assign w_aidx   = (r_item.anchor_index > LAST_ANCHOR) ? LAST_ANCHOR
                                                          : r_item.anchor_index;
    assign w_size   = i_cfg.anchor_size[w_aidx];
    assign w_size_s = signed'({1'b0, w_size});
    assign w_raw    = i_cmd.sel_b ? r_item.delta_b : r_item.delta_a;

    assign w_pair_zero   = (r_item.pair_index == abld_pkg::PAIR_CENTRE);
    assign w_pt          = r_item.pair_index - abld_pkg::PAIR_FIRST_LANDMARK;
    assign w_landmark_ok = (r_item.pair_index >= abld_pkg::PAIR_FIRST_LANDMARK)
                           && ({1'b0, w_pt} < LP_W);
    assign w_last        = ({1'b0, w_pt} == (LP_W - 4'd1));

    assign w_place_a = place_sum(r_prod_a, r_base_x);
    assign w_place_b = place_sum(r_prod_b, r_base_y);

    // shared multiplier operand: exp fraction factor or anchor size
    assign w_mul_op = i_cmd.size_mul ? 17'(w_size) : abld_pkg::EXP_FRAC[i_cmd.bit_idx];

    // recombine the two partial products and round
    assign w_acc = {1'b0, r_phi, 18'd0} + 54'(r_plo)
                   + (i_cmd.size_add ? ROUND_SIZE : ROUND_EXP);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_item;
        end
        if (i_cmd.place_mul) begin
            r_prod_a <= 27'(r_item.delta_a) * 27'(w_size_s);
            r_prod_b <= 27'(r_item.delta_b) * 27'(w_size_s);
            r_base_x <= 17'(r_item.grid_col) * 17'(i_cfg.grid_stride);
            r_base_y <= 17'(r_item.grid_row) * 17'(i_cfg.grid_stride);
        end
        if (i_cmd.exp_init) begin
            r_e <= abld_pkg::EXP_INT[{~w_raw[15], w_raw[14:12]}];
        end else if (i_cmd.exp_add) begin
            r_e <= w_acc[51:16];
        end
        if (i_cmd.exp_mul || i_cmd.size_mul) begin
            r_plo <= 35'(r_e[17:0]) * 35'(w_mul_op);
            r_phi <= 35'(r_e[35:18]) * 35'(w_mul_op);
        end
        if (i_cmd.size_add) begin
            if (i_cmd.sel_b) begin
                r_hh <= w_acc[46:17];
            end else begin
                r_hw <= w_acc[46:17];
            end
        end
        if (i_cmd.place_fin && !w_pair_zero) begin
            r_res.record_kind    <= abld_pkg::REC_POINT;
            r_res.value_a        <= w_place_a;
            r_res.value_b        <= w_place_b;
            r_res.value_c        <= '0;
            r_res.value_d        <= '0;
            r_res.kept_score     <= r_held_score;
            r_res.point_number   <= w_pt;
            r_res.last_of_anchor <= w_last;
        end else if (i_cmd.box_fin) begin
            r_res.record_kind    <= abld_pkg::REC_BOX;
            r_res.value_a        <= sat24(32'(r_cy) - 32'(signed'({1'b0, r_hh})));
            r_res.value_b        <= sat24(32'(r_cx) - 32'(signed'({1'b0, r_hw})));
            r_res.value_c        <= sat24(32'(r_cy) + 32'(signed'({1'b0, r_hh})));
            r_res.value_d        <= sat24(32'(r_cx) + 32'(signed'({1'b0, r_hw})));
            r_res.kept_score     <= r_held_score;
            r_res.point_number   <= '0;
            r_res.last_of_anchor <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    // anchor state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_passed     <= 1'b0;
            r_cx         <= '0;
            r_cy         <= '0;
            r_held_score <= '0;
        end else if (i_cmd.place_fin) begin
            if (w_pair_zero) begin
                if (r_item.score >= i_cfg.min_score) begin
                    r_passed     <= 1'b1;
                    r_held_score <= r_item.score;
                    r_cx         <= w_place_a;
                    r_cy         <= w_place_b;
                end else begin
                    r_passed <= 1'b0;
                end
            end else if (w_last) begin
                r_passed <= 1'b0;
            end
        end
    end

    assign o_status.pair_zero   = w_pair_zero;
    assign o_status.pair_size   = (r_item.pair_index == abld_pkg::PAIR_SIZE);
    assign o_status.landmark_ok = w_landmark_ok;
    assign o_status.passed      = r_passed;
    assign o_status.frac_set    = w_raw[i_cmd.bit_idx];

    assign o_result = r_out;

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.place_fin && !w_pair_zero && w_last) |=> !r_passed)
        else $error("anchor still open after its final landmark");

endmodule

// ----- src/anchor_box_landmark_decoder_top.sv -----
// anchor box and landmark decoder. each anchor arrives as seven requests that share grid
// position and anchor index: pair 0 carries centre deltas and score, pair 1 the log size
// deltas, pairs 2 to 6 the landmark deltas. an anchor below the score threshold gives no
// results; otherwise pair 1 gives one box record (top, left, bottom, right, score) and
// each landmark pair one point record, the last flagged last_of_anchor. deltas are q4.12,
// scores q0.16, coordinates q16.8 saturated to 24 bits. one request is worked at a time;
// pair 1 takes longer the more fraction bits are set over both size deltas, since the exp
// sequencer walks the 12 fraction bits of each delta through one shared pair of 18 x 17
// bit multipliers, testing a clear bit only and testing, multiplying and adding for a set
// one, then scales by the anchor size on the same multipliers. a finished record waits
// in the output register, and the next request is taken while it waits. registers are
// written through a plain write port and should only change while the block is idle
module anchor_box_landmark_decoder_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [abld_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [abld_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    abld_in_if.sink                            i_in,
    abld_out_if.source                         o_out
);

    abld_pkg::t_cfg        w_cfg;
    abld_pkg::t_dp_cmd     w_cmd;
    abld_pkg::t_dp_status  w_status;
    abld_pkg::t_out_item   w_result;
    logic                  w_in_ready;
    logic                  w_out_valid;

    // score threshold, stride and the four anchor sizes
    abld_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // sequencer: owns both handshakes and the fraction bit counter
    abld_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // arithmetic, anchor state and the output register
    abld_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_item   (i_in.data),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .o_result (w_result)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;
    assign o_out.data  = w_result;

endmodule

// ----- verif/abld_check_pkg.sv -----
`timescale 1ns / 1ps
package abld_check_pkg;
    import abld_pkg::*;

    // predicts the decoder's records and checks what comes out against them
    class abld_record_check;
        logic [15:0]        threshold;
        logic [6:0]         stride;
        logic [9:0]         side [ANCHOR_REGS];

        bit                 passed;
        logic signed [23:0] centre_x;
        logic signed [23:0] centre_y;
        logic [15:0]        held_score;

        t_out_item          records_due [$];
        int                 errors;
        int                 boxes_seen;
        int                 points_seen;

        function new();
            threshold  = 16'd32768;
            stride     = 7'd4;
            side[0]    = 10'd16;
            side[1]    = 10'd32;
            side[2]    = 10'd64;
            side[3]    = 10'd128;
            passed     = 1'b0;
            centre_x   = '0;
            centre_y   = '0;
            held_score = '0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_MIN_SCORE:       threshold = val;
                CFG_GRID_STRIDE:     stride    = val[6:0];
                CFG_ANCHOR_SIZE_0:   side[0]   = val[9:0];
                CFG_ANCHOR_SIZE_1:   side[1]   = val[9:0];
                CFG_ANCHOR_SIZE_2:   side[2]   = val[9:0];
                CFG_ANCHOR_SIZE_3:   side[3]   = val[9:0];
                default: ;
            endcase
        endfunction

        function longint clamp24(longint v);
            if (v > 64'sd8388607) return 64'sd8388607;
            if (v < -64'sd8388608) return -64'sd8388608;
            return v;
        endfunction

        // delta times anchor side, rounded to q16.8, plus the cell origin
        function longint place(longint delta, longint size, longint grid);
            longint scaled;
            scaled = (delta * size + 8) >>> 4;
            return clamp24(scaled + grid * longint'(stride) * 256);
        endfunction

        // half of exp(delta) times the side, in q16.8
        function longint half_side(logic [15:0] raw, longint unsigned size);
            longint unsigned e;
            e = 64'(EXP_INT[raw[15:12] ^ 4'd8]);
            for (int k = FRAC_BITS - 1; k >= 0; k--) begin
                if (raw[k]) e = (e * EXP_FRAC[k] + 64'd32768) >> 16;
            end
            return longint'((e * size + 64'd65536) >> 17);
        endfunction

        function void note_request(t_in_item req);
            int unsigned       which;
            longint unsigned   size;
            longint            da;
            longint            db;
            longint            row;
            longint            col;
            longint            hw;
            longint            hh;
            int                pt;
            t_out_item         rec;

            which = 32'(req.anchor_index);
            if (which >= ANCHORS) which = ANCHORS - 1;
            size = 64'(side[which]);
            da   = longint'($signed(req.delta_a));
            db   = longint'($signed(req.delta_b));
            row  = longint'(req.grid_row);
            col  = longint'(req.grid_col);

            if (req.pair_index == PAIR_CENTRE) begin
                if (req.score >= threshold) begin
                    passed     = 1'b1;
                    held_score = req.score;
                    centre_x   = 24'(place(da, size, col));
                    centre_y   = 24'(place(db, size, row));
                end else begin
                    passed = 1'b0;
                end
                return;
            end
            if (!passed) return;

            rec = '0;
            rec.kept_score = held_score;
            if (req.pair_index == PAIR_SIZE) begin
                hw = half_side(req.delta_a, size);
                hh = half_side(req.delta_b, size);
                rec.record_kind = REC_BOX;
                rec.value_a = 24'(clamp24(longint'(centre_y) - hh));
                rec.value_b = 24'(clamp24(longint'(centre_x) - hw));
                rec.value_c = 24'(clamp24(longint'(centre_y) + hh));
                rec.value_d = 24'(clamp24(longint'(centre_x) + hw));
            end else begin
                pt = int'(req.pair_index) - int'(PAIR_FIRST_LANDMARK);
                if (pt >= LANDMARK_POINTS) return;
                rec.record_kind    = REC_POINT;
                rec.value_a        = 24'(place(da, size, col));
                rec.value_b        = 24'(place(db, size, row));
                rec.point_number   = pt[2:0];
                rec.last_of_anchor = (pt == LANDMARK_POINTS - 1);
                if (rec.last_of_anchor) passed = 1'b0;
            end
            records_due.push_back(rec);
        endfunction

        function void compare_record(t_out_item got);
            t_out_item want;
            bit        bad;

            if (records_due.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected record: kind %0d a %0d b %0d c %0d d %0d",
                             got.record_kind, $signed(got.value_a), $signed(got.value_b),
                             $signed(got.value_c), $signed(got.value_d),
                             " score %0d pt %0d last %0d",
                             got.kept_score, got.point_number, got.last_of_anchor);
                return;
            end
            want = records_due.pop_front();
            bad = (got.record_kind !== want.record_kind) || (got.value_a !== want.value_a) ||
                  (got.value_b !== want.value_b) || (got.value_c !== want.value_c) ||
                  (got.value_d !== want.value_d) || (got.kept_score !== want.kept_score) ||
                  (got.point_number !== want.point_number) ||
                  (got.last_of_anchor !== want.last_of_anchor);
            if (bad) begin
                errors++;
                if (errors <= 10)
                    $display("record mismatch (exp/act): kind %0d/%0d",
                             want.record_kind, got.record_kind,
                             " a %0d/%0d", $signed(want.value_a), $signed(got.value_a),
                             " b %0d/%0d", $signed(want.value_b), $signed(got.value_b),
                             " c %0d/%0d", $signed(want.value_c), $signed(got.value_c),
                             " d %0d/%0d", $signed(want.value_d), $signed(got.value_d),
                             " score %0d/%0d", want.kept_score, got.kept_score,
                             " pt %0d/%0d", want.point_number, got.point_number,
                             " last %0d/%0d", want.last_of_anchor, got.last_of_anchor);
            end
            if (want.record_kind == REC_BOX) boxes_seen++;
            else points_seen++;
        endfunction
    endclass

endpackage

// ----- verif/anchor_box_landmark_decoder_top_tb.sv -----
`timescale 1ns / 1ps
module anchor_box_landmark_decoder_top_tb;
    import abld_pkg::*;
    import abld_check_pkg::*;

    // wait to let a request that gives nothing finish
    localparam int SETTLE = 100;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    abld_in_if  req_if ();
    abld_out_if rec_if ();

    anchor_box_landmark_decoder_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (req_if),
        .o_out       (rec_if)
    );

    abld_record_check book;

    bit idle_on;        // random gaps and stalls allowed
    bit quiet;          // a stretch with no idling on either side
    int sent;
    int settings_used;
    int stall_left;

    always #4 i_clk = ~i_clk;

    // generous fixed limit, several times the slowest legal run
    initial begin
        #3_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // record side: check every accepted record, stall in random bursts
    always @(posedge i_clk) begin
        if (i_rst_n && rec_if.valid && rec_if.ready) book.compare_record(rec_if.data);
        if (stall_left > 0) begin
            stall_left--;
            rec_if.ready <= 1'b0;
        end else if (idle_on && !quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 7);
            rec_if.ready <= 1'b0;
        end else begin
            rec_if.ready <= 1'b1;
        end
    end

    function automatic t_in_item mk(input int row, input int col, input int ai, input int score,
                                    input logic [2:0] pair, input logic [15:0] da,
                                    input logic [15:0] db);
        t_in_item it;
        it.grid_row     = row[9:0];
        it.grid_col     = col[9:0];
        it.anchor_index = ai[1:0];
        it.score        = score[15:0];
        it.pair_index   = pair;
        it.delta_a      = da;
        it.delta_b      = db;
        return it;
    endfunction

    // extremes, full range or values that keep coordinates in range
    function automatic logic [15:0] pick_delta();
        int sel;
        sel = $urandom_range(0, 5);
        case (sel)
            0: return 16'h7fff;
            1: return 16'h8000;
            2, 3: return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(0, 8191) - 4096);
        endcase
    endfunction

    function automatic logic [9:0] pick_grid();
        if ($urandom_range(0, 1) == 0) return 10'($urandom_range(0, 63));
        return 10'($urandom_range(0, 1023));
    endfunction

    // one request, with an optional gap of idle cycles before it
    task automatic send_req(input t_in_item it);
        int gap;
        if (idle_on && !quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= it;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        book.note_request(it);
        sent++;
    endtask

    // hold off until every record is home, then let the block settle
    task automatic drain();
        req_if.valid <= 1'b0;
        while (book.records_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // all six registers, then junk to the two unused indexes
    task automatic apply_setting(input logic [15:0] thr, input logic [15:0] stride,
                                 input logic [15:0] s0, input logic [15:0] s1,
                                 input logic [15:0] s2, input logic [15:0] s3);
        logic [15:0] vals [8];
        vals[0] = thr;
        vals[1] = stride;
        vals[2] = s0;
        vals[3] = s1;
        vals[4] = s2;
        vals[5] = s3;
        vals[6] = 16'($urandom_range(0, 65535));
        vals[7] = 16'($urandom_range(0, 65535));
        for (int i = 0; i < 8; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= i[2:0];
            i_cfg_data  <= vals[i];
            @(posedge i_clk);
            book.write_reg(i[2:0], vals[i]);
        end
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic random_setting();
        apply_setting(16'($urandom_range(0, 65535)), 16'($urandom_range(1, 64)),
                      16'($urandom_range(1, 1023)), 16'($urandom_range(1, 1023)),
                      16'($urandom_range(1, 1023)), 16'($urandom_range(1, 1023)));
    endtask

    // seven requests of one anchor; a broken one drops, repeats or trails requests
    task automatic send_anchor(input bit broken);
        t_in_item base;
        t_in_item it;
        base.grid_row     = pick_grid();
        base.grid_col     = pick_grid();
        base.anchor_index = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 4) == 0) base.score = 16'($urandom_range(0, 65535));
        else base.score = 16'($urandom_range(65535, int'(book.threshold)));
        quiet = ($urandom_range(0, 3) == 0);
        for (int p = 0; p < 7; p++) begin
            it            = base;
            it.pair_index = p[2:0];
            it.delta_a    = pick_delta();
            it.delta_b    = pick_delta();
            if (p != 0) it.score = 16'($urandom_range(0, 65535));
            if (broken && $urandom_range(0, 4) == 0) continue;
            send_req(it);
            if (broken && $urandom_range(0, 4) == 0) begin
                it.delta_a = pick_delta();
                it.delta_b = pick_delta();
                send_req(it);
            end
        end
        if (broken) begin
            it            = base;
            it.pair_index = 3'($urandom_range(1, 7));
            it.delta_a    = pick_delta();
            it.delta_b    = pick_delta();
            send_req(it);
        end
    endtask

    task automatic send_noise();
        t_in_item it;
        quiet = 1'b0;
        it.grid_row     = 10'($urandom_range(0, 1023));
        it.grid_col     = 10'($urandom_range(0, 1023));
        it.anchor_index = 2'($urandom_range(0, 3));
        it.score        = 16'($urandom_range(0, 65535));
        it.pair_index   = 3'($urandom_range(0, 7));
        it.delta_a      = 16'($urandom_range(0, 65535));
        it.delta_b      = 16'($urandom_range(0, 65535));
        send_req(it);
    endtask

    // mostly well-formed anchors, some broken ones and loose requests
    task automatic random_part(input int count);
        int goal;
        int roll;
        goal = sent + count;
        while (sent < goal) begin
            roll = $urandom_range(0, 19);
            if (roll < 15) send_anchor(1'b0);
            else if (roll < 18) send_anchor(1'b1);
            else send_noise();
        end
    endtask

    initial begin
        book          = new();
        req_if.valid  = 1'b0;
        req_if.data   = '0;
        rec_if.ready  = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        i_rst_n       = 1'b0;
        idle_on       = 1'b1;
        quiet         = 1'b0;
        sent          = 0;
        settings_used = 1;
        stall_left    = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: score exactly at the threshold passes
        send_req(mk(0, 0, 0, 32768, PAIR_CENTRE, 16'h7fff, 16'h8000));
        // smallest and largest exp
        send_req(mk(0, 0, 0, 0, PAIR_SIZE, 16'h8000, 16'h7fff));
        send_req(mk(0, 0, 0, 0, 3'd2, 16'h7fff, 16'h8000));
        send_req(mk(0, 0, 0, 0, 3'd3, 16'h8000, 16'h7fff));
        send_req(mk(0, 0, 0, 0, 3'd4, 16'h0000, 16'hffff));
        send_req(mk(0, 0, 0, 0, 3'd5, 16'h0001, 16'h0000));
        send_req(mk(0, 0, 0, 0, 3'd6, 16'h7fff, 16'h7fff));
        // stray landmark after the last point, and the unused pair code
        send_req(mk(0, 0, 0, 0, 3'd4, 16'h1234, 16'h4321));
        send_req(mk(0, 0, 0, 0, 3'd7, 16'h1234, 16'h4321));
        // one below the threshold, then nothing should follow
        send_req(mk(1023, 1023, 3, 32767, PAIR_CENTRE, 16'h0100, 16'h0100));
        send_req(mk(1023, 1023, 3, 0, PAIR_SIZE, 16'h0100, 16'h0100));
        send_req(mk(1023, 1023, 3, 0, 3'd3, 16'h0100, 16'h0100));
        // far corner, largest anchor, full score
        send_req(mk(1023, 1023, 3, 65535, PAIR_CENTRE, 16'h7fff, 16'h7fff));
        send_req(mk(1023, 1023, 3, 0, PAIR_SIZE, 16'h0000, 16'h0fff));
        // repeated size pair from the held centre
        send_req(mk(1023, 1023, 3, 0, PAIR_SIZE, 16'h1000, 16'hf000));
        // unused pair code while an anchor is open
        send_req(mk(1023, 1023, 3, 0, 3'd7, 16'h7fff, 16'h8000));
        send_req(mk(1023, 1023, 3, 0, 3'd2, 16'h8000, 16'h8000));
        send_req(mk(1023, 1023, 3, 0, 3'd3, 16'h7fff, 16'h7fff));
        send_req(mk(1023, 1023, 3, 0, 3'd4, 16'h8000, 16'h7fff));
        send_req(mk(1023, 1023, 3, 0, 3'd5, 16'h7fff, 16'h8000));
        send_req(mk(1023, 1023, 3, 0, 3'd6, 16'h0000, 16'h0000));
        // zero score fails
        send_req(mk(5, 7, 1, 0, PAIR_CENTRE, 16'h0000, 16'h0000));
        // last landmark alone closes the anchor
        send_req(mk(12, 34, 2, 40000, PAIR_CENTRE, 16'hf800, 16'h0800));
        send_req(mk(12, 34, 2, 0, 3'd6, 16'h0400, 16'hfc00));
        send_req(mk(12, 34, 2, 0, 3'd2, 16'h0400, 16'hfc00));
        random_part(80);
        drain();

        // upper extremes: everything passes, coordinates saturate
        apply_setting(16'd0, 16'd64, 16'd1023, 16'd1023, 16'd1023, 16'd1023);
        random_part(100);
        drain();

        // lower extremes: only a full score passes
        apply_setting(16'hffff, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
        random_part(60);
        drain();

        // zero stride and zero sizes used as they are
        apply_setting(16'($urandom_range(0, 65535)), 16'd0, 16'd0, 16'd1023, 16'd1, 16'd0);
        random_part(100);
        drain();

        // random setting, sender holds off part way through
        random_setting();
        random_part(60);
        drain();
        random_part(60);
        drain();

        // raw 16 bit data into every register
        apply_setting(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        random_part(100);
        drain();

        // closing stretch at full rate on both sides
        idle_on = 1'b0;
        random_setting();
        random_part(100);
        drain();

        $display("ran %0d requests over %0d register settings, extremes and zeros among them",
                 sent, settings_used);
        $display("checked %0d box records and %0d landmark records",
                 book.boxes_seen, book.points_seen);
        if (book.errors == 0 && book.records_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
